// File: hdl/les_pkg.sv
// ----------------------------------------------------------------------------
// les_pkg
// Shared types and constants of the LED effect sequencer.
// ----------------------------------------------------------------------------
package les_pkg;

  localparam int TABLE_DEPTH     = 8;
  localparam int TBL_IDX_W       = 3;
  localparam int PULSE_GAP_TICKS = 500;
  localparam int TSS_W           = 18;
  localparam int DUTY_W          = 16;
  localparam int IVL_W           = 16;
  localparam int PLEN_W          = 4;
  localparam int STEP_W          = 8;

  localparam logic signed [TSS_W-1:0] TSS_MAX = TSS_W'((2 ** (TSS_W - 1)) - 1);
  localparam logic signed [TSS_W-1:0] TSS_GAP = -TSS_W'(PULSE_GAP_TICKS);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_ON       = 3'd1,
    MODE_BLINK    = 3'd2,
    MODE_BREATHE  = 3'd3,
    MODE_PULSE    = 3'd4,
    MODE_FADE_IN  = 3'd5,
    MODE_FADE_OUT = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_ON     = 3'd2,
    OP_OFF    = 3'd3,
    OP_PAUSE  = 3'd4,
    OP_RESUME = 3'd5,
    OP_LOAD   = 3'd6
  } op_t;

  localparam logic [2:0] EFF_LAST = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHT_STEP    = 2'd0,
    REG_LEVEL_MAX      = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0] bright_step;
    logic [DUTY_W-1:0] level_max;
    logic [PLEN_W-1:0] pattern_length;
  } les_cfg_t;

  typedef struct packed {
    mode_t                   mode_now;
    mode_t                   mode_before;
    logic [DUTY_W-1:0]       duty_level;
    logic                    ramp_down;
    logic signed [TSS_W-1:0] ticks_since_step;
    logic                    never_acted;
    logic [TBL_IDX_W-1:0]    table_cursor;
    logic                    pin_high;
    logic [IVL_W-1:0]        latched_interval;
  } les_state_t;

endpackage

// File: hdl/les_update.sv
// ----------------------------------------------------------------------------
// les_update
// Next-state logic of the sequencer for one tick or command.
// ----------------------------------------------------------------------------
module les_update (
  input  les_pkg::les_state_t    cur,
  input  les_pkg::les_cfg_t      cfg,
  input  logic [2:0]             op,
  input  logic [2:0]             effect,
  input  logic [15:0]            step_interval,
  input  logic [15:0]            entry_at_cursor,
  output les_pkg::les_state_t    nxt
);

  function automatic logic is_cyclic(input les_pkg::mode_t m);
    return (m == les_pkg::MODE_BLINK) || (m == les_pkg::MODE_BREATHE) ||
           (m == les_pkg::MODE_PULSE);
  endfunction

  logic signed [les_pkg::TSS_W-1:0]  tss_inc;
  logic                              due;
  logic                              blink_due;
  logic [les_pkg::DUTY_W:0]          sum_w;
  logic [les_pkg::DUTY_W-1:0]        duty_add;
  logic [les_pkg::DUTY_W-1:0]        duty_sub;
  logic [les_pkg::DUTY_W-1:0]        step_ext;
  logic [les_pkg::DUTY_W-1:0]        duty_brth;
  logic [les_pkg::PLEN_W-1:0]        len;
  logic [les_pkg::PLEN_W-1:0]        cur_inc;
  les_pkg::mode_t                    target;

  always_comb begin
    tss_inc   = (cur.ticks_since_step < les_pkg::TSS_MAX) ?
                cur.ticks_since_step + $signed(les_pkg::TSS_W'(1)) :
                cur.ticks_since_step;
    due       = cur.never_acted ||
                (tss_inc > $signed({2'b00, cur.latched_interval}));
    blink_due = tss_inc > $signed({2'b00, entry_at_cursor});
    step_ext  = {{(les_pkg::DUTY_W - les_pkg::STEP_W){1'b0}}, cfg.bright_step};
    sum_w     = {1'b0, cur.duty_level} + {1'b0, step_ext};
    duty_add  = (sum_w > {1'b0, cfg.level_max}) ? cfg.level_max :
                sum_w[les_pkg::DUTY_W-1:0];
    duty_sub  = (cur.duty_level > step_ext) ? cur.duty_level - step_ext : '0;
    duty_brth = cur.ramp_down ? duty_sub : duty_add;
    if (cfg.pattern_length == '0) begin
      len = les_pkg::PLEN_W'(1);
    end else if (cfg.pattern_length > les_pkg::PLEN_W'(les_pkg::TABLE_DEPTH)) begin
      len = les_pkg::PLEN_W'(les_pkg::TABLE_DEPTH);
    end else begin
      len = cfg.pattern_length;
    end
    cur_inc = {1'b0, cur.table_cursor} + les_pkg::PLEN_W'(1);
    target  = les_pkg::mode_t'(effect + 3'd2);

    nxt = cur;
    case (les_pkg::op_t'(op))
      les_pkg::OP_TICK: begin
        nxt.ticks_since_step = tss_inc;
        case (cur.mode_now)
          les_pkg::MODE_BLINK: begin
            if (cur.never_acted) begin
              nxt.pin_high         = 1'b1;
              nxt.never_acted      = 1'b0;
              nxt.ticks_since_step = '0;
            end else if (blink_due) begin
              nxt.pin_high         = !cur.pin_high;
              nxt.table_cursor     = (cur_inc >= len) ? '0 :
                                     cur_inc[les_pkg::TBL_IDX_W-1:0];
              nxt.never_acted      = 1'b0;
              nxt.ticks_since_step = '0;
            end
          end
          les_pkg::MODE_BREATHE: begin
            if (due) begin
              nxt.never_acted      = 1'b0;
              nxt.ticks_since_step = '0;
              nxt.duty_level       = duty_brth;
              if ((duty_brth == '0) || (duty_brth >= cfg.level_max)) begin
                nxt.ramp_down = !cur.ramp_down;
              end
            end
          end
          les_pkg::MODE_PULSE: begin
            if (due) begin
              nxt.never_acted = 1'b0;
              if (cur.duty_level < step_ext) begin
                nxt.duty_level       = cfg.level_max;
                nxt.ticks_since_step = les_pkg::TSS_GAP;
              end else begin
                nxt.duty_level       = cur.duty_level - step_ext;
                nxt.ticks_since_step = '0;
              end
            end
          end
          les_pkg::MODE_FADE_IN: begin
            if ((cur.duty_level < cfg.level_max) && due) begin
              nxt.never_acted      = 1'b0;
              nxt.ticks_since_step = '0;
              nxt.duty_level       = duty_add;
              if (duty_add == cfg.level_max) begin
                nxt.mode_now = les_pkg::MODE_ON;
              end
            end
          end
          les_pkg::MODE_FADE_OUT: begin
            if ((cur.duty_level != '0) && due) begin
              nxt.never_acted      = 1'b0;
              nxt.ticks_since_step = '0;
              nxt.duty_level       = duty_sub;
              if (duty_sub == '0) begin
                nxt.mode_before = cur.mode_now;
                nxt.mode_now    = les_pkg::MODE_OFF;
              end
            end
          end
          default: begin
          end
        endcase
      end
      les_pkg::OP_START: begin
        if (effect <= les_pkg::EFF_LAST) begin
          if ((cur.mode_now != target) && (cur.mode_now != les_pkg::MODE_OFF)) begin
            nxt.mode_before = cur.mode_now;
          end
          if (target == les_pkg::MODE_BLINK) begin
            nxt.table_cursor = '0;
            nxt.never_acted  = 1'b1;
          end else begin
            nxt.latched_interval = step_interval;
            nxt.duty_level = ((target == les_pkg::MODE_PULSE) ||
                              (target == les_pkg::MODE_FADE_OUT)) ? cfg.level_max : '0;
          end
          nxt.mode_now = target;
        end
      end
      les_pkg::OP_ON: begin
        if ((cur.mode_now != les_pkg::MODE_ON) && (cur.mode_now != les_pkg::MODE_OFF) &&
            is_cyclic(cur.mode_now)) begin
          nxt.table_cursor = '0;
          nxt.pin_high     = 1'b0;
          nxt.mode_before  = cur.mode_now;
          nxt.never_acted  = 1'b1;
        end
        nxt.mode_now = les_pkg::MODE_ON;
      end
      les_pkg::OP_OFF: begin
        nxt.mode_before = cur.mode_now;
        nxt.mode_now    = les_pkg::MODE_OFF;
      end
      les_pkg::OP_PAUSE: begin
        if (is_cyclic(cur.mode_now)) begin
          nxt.table_cursor = '0;
          nxt.pin_high     = 1'b0;
          nxt.mode_before  = cur.mode_now;
          nxt.mode_now     = les_pkg::MODE_OFF;
          nxt.never_acted  = 1'b1;
        end
      end
      les_pkg::OP_RESUME: begin
        if (is_cyclic(cur.mode_before)) begin
          if (cur.mode_before == les_pkg::MODE_BREATHE) begin
            nxt.duty_level = '0;
          end else if (cur.mode_before == les_pkg::MODE_PULSE) begin
            nxt.duty_level = cfg.level_max;
          end
          nxt.mode_now    = cur.mode_before;
          nxt.mode_before = les_pkg::MODE_OFF;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/led_effect_sequencer_core.sv
// ----------------------------------------------------------------------------
// led_effect_sequencer_core
// Blink, breathe, pulse and fade sequencer for one LED, driven by a stream
// of ticks and commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per tick or command; in_tuser carries the op.
//   out_* : exactly one result transaction per input transaction, in order,
//           giving pin level, PWM enable, PWM duty and current effect.
//   cfg_* : register writes (bright_step, level_max, pattern_length);
//           cfg_ready is always high. Write only while the block is idle.
// Output: the result is registered and appears in the cycle after its input is accepted.
// Throughput: one item per cycle while out_tready is high; the state update is a single pass of
//   compare and add/subtract logic between the state and output registers.
// Reset: rst_n low puts the block in off mode, drops out_tvalid and
//   restores register defaults. Blink table entries stay undefined
//   until loaded.
// Stall: while a result waits with out_tready low, in_tready is low; the
//   result register frees as soon as it is taken, so a new item may be
//   accepted in the same cycle.
// ----------------------------------------------------------------------------
module led_effect_sequencer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // effect[2:0], step_interval[18:3], entry_index[21:19], entry_value[37:22]
  input  logic [les_pkg::IN_DATA_W-1:0]    in_tdata,
  // op[2:0]
  input  logic [2:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // led_level[0], pwm_active[1], pwm_duty[17:2], effect_state[20:18]
  output logic [les_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [les_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [les_pkg::CFG_DATA_W-1:0]   cfg_data
);

  les_pkg::les_cfg_t   cfg_r;
  les_pkg::les_state_t state_r;
  les_pkg::les_state_t state_nxt;
  logic [15:0]         blink_table_r [les_pkg::TABLE_DEPTH];
  logic                out_tvalid_r;
  logic [les_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [les_pkg::OUT_DATA_W-1:0] out_tdata_nxt;
  logic                in_acc;
  logic [2:0]          in_effect;
  logic [15:0]         in_interval;
  logic [2:0]          in_index;
  logic [15:0]         in_value;
  logic                pwm_nxt;

  assign in_effect   = in_tdata[2:0];
  assign in_interval = in_tdata[18:3];
  assign in_index    = in_tdata[21:19];
  assign in_value    = in_tdata[37:22];

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  les_update u_update (
    .cur             (state_r),
    .cfg             (cfg_r),
    .op              (in_tuser),
    .effect          (in_effect),
    .step_interval   (in_interval),
    .entry_at_cursor (blink_table_r[state_r.table_cursor]),
    .nxt             (state_nxt)
  );

  always_comb begin
    pwm_nxt = (state_nxt.mode_now == les_pkg::MODE_BREATHE) ||
              (state_nxt.mode_now == les_pkg::MODE_PULSE) ||
              (state_nxt.mode_now == les_pkg::MODE_FADE_IN) ||
              (state_nxt.mode_now == les_pkg::MODE_FADE_OUT);
    out_tdata_nxt        = '0;
    out_tdata_nxt[0]     = (state_nxt.mode_now == les_pkg::MODE_ON) ||
                           ((state_nxt.mode_now == les_pkg::MODE_BLINK) &&
                            state_nxt.pin_high);
    out_tdata_nxt[1]     = pwm_nxt;
    out_tdata_nxt[17:2]  = pwm_nxt ? state_nxt.duty_level : '0;
    out_tdata_nxt[20:18] = state_nxt.mode_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bright_step    <= 8'd1;
      cfg_r.level_max      <= 16'd255;
      cfg_r.pattern_length <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (les_pkg::reg_idx_t'(cfg_index))
        les_pkg::REG_BRIGHT_STEP:    cfg_r.bright_step    <= cfg_data[7:0];
        les_pkg::REG_LEVEL_MAX:      cfg_r.level_max      <= cfg_data;
        les_pkg::REG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode_now         <= les_pkg::MODE_OFF;
      state_r.mode_before      <= les_pkg::MODE_OFF;
      state_r.duty_level       <= '0;
      state_r.ramp_down        <= 1'b0;
      state_r.ticks_since_step <= '0;
      state_r.never_acted      <= 1'b1;
      state_r.table_cursor     <= '0;
      state_r.pin_high         <= 1'b0;
      state_r.latched_interval <= '0;
      out_tvalid_r             <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r <= state_nxt;
      end
      if (in_acc) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_tdata_r <= out_tdata_nxt;
    end
    if (in_acc && (les_pkg::op_t'(in_tuser) == les_pkg::OP_LOAD) &&
        (int'(in_index) < les_pkg::TABLE_DEPTH)) begin
      blink_table_r[in_index] <= in_value;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted transaction produced no result");

  a_off_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == les_pkg::OP_OFF) |=>
      (state_r.mode_now == les_pkg::MODE_OFF) && (out_tdata[20:18] == les_pkg::MODE_OFF))
    else $error("off command did not turn the LED off");

  a_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == les_pkg::OP_ON) |=>
      out_tdata[0] && !out_tdata[1])
    else $error("on command did not drive the pin high");

  a_tss_floor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.ticks_since_step >= les_pkg::TSS_GAP)
    else $error("tick counter below pulse gap start");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams ticks and commands into led_effect_sequencer_core with random gaps
// and output stalls. An in-bench behavioral predictor models pin level, PWM
// duty and effect state; every result transaction is checked field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_CAP   = 100;

  localparam logic [2:0] EFF_BLINK    = 3'd0;
  localparam logic [2:0] EFF_BREATHE  = 3'd1;
  localparam logic [2:0] EFF_PULSE    = 3'd2;
  localparam logic [2:0] EFF_FADE_IN  = 3'd3;
  localparam logic [2:0] EFF_FADE_OUT = 3'd4;
  localparam logic [2:0] CODE_MAX     = 3'd7;

  typedef struct packed {
    les_pkg::mode_t             state;
    logic [les_pkg::DUTY_W-1:0] duty;
    logic                       pwm;
    logic                       led;
  } led_out_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [les_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [2:0]                     in_tuser   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b1;
  logic [les_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [les_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [les_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  led_effect_sequencer_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted block state and register copies
  les_pkg::mode_t                   p_mode    = les_pkg::MODE_OFF;
  les_pkg::mode_t                   p_prev    = les_pkg::MODE_OFF;
  logic [les_pkg::DUTY_W-1:0]       p_duty    = '0;
  logic                             p_falling = 1'b0;
  logic signed [les_pkg::TSS_W-1:0] p_elapsed = '0;
  logic                             p_fresh   = 1'b1;
  logic [les_pkg::TBL_IDX_W-1:0]    p_slot    = '0;
  logic                             p_pin     = 1'b0;
  logic [les_pkg::IVL_W-1:0]        p_period  = '0;
  logic [15:0]                      p_phase [les_pkg::TABLE_DEPTH];
  logic [les_pkg::STEP_W-1:0]       c_step    = 8'd1;
  logic [les_pkg::DUTY_W-1:0]       c_full    = 16'd255;
  logic [les_pkg::PLEN_W-1:0]       c_plen    = 4'd2;

  led_out_t pending_led_q [$];
  int       n_mismatch   = 0;
  int       items_sent   = 0;
  int       cycle_count  = 0;
  int       stall_left   = 0;
  bit       src_idle_en  = 1'b0;
  bit       sink_idle_en = 1'b0;

  function automatic bit is_cyclic(les_pkg::mode_t m);
    return m == les_pkg::MODE_BLINK || m == les_pkg::MODE_BREATHE ||
           m == les_pkg::MODE_PULSE;
  endfunction

  function automatic void halt_cyclic();
    if (is_cyclic(p_mode)) begin
      p_slot  = '0;
      p_pin   = 1'b0;
      p_prev  = p_mode;
      p_mode  = les_pkg::MODE_OFF;
      p_fresh = 1'b1;
    end
  endfunction

  function automatic void to_off();
    p_prev = p_mode;
    p_mode = les_pkg::MODE_OFF;
  endfunction

  function automatic void to_on();
    if (p_mode != les_pkg::MODE_ON && p_mode != les_pkg::MODE_OFF) halt_cyclic();
    p_mode = les_pkg::MODE_ON;
  endfunction

  function automatic logic [les_pkg::DUTY_W-1:0] duty_up(logic [les_pkg::DUTY_W-1:0] a);
    logic [les_pkg::DUTY_W:0] s;
    s = (les_pkg::DUTY_W+1)'(a) + (les_pkg::DUTY_W+1)'(c_step);
    return (s > (les_pkg::DUTY_W+1)'(c_full)) ? c_full : s[les_pkg::DUTY_W-1:0];
  endfunction

  function automatic logic [les_pkg::DUTY_W-1:0] duty_down(logic [les_pkg::DUTY_W-1:0] a);
    return (a > les_pkg::DUTY_W'(c_step)) ? a - les_pkg::DUTY_W'(c_step) : '0;
  endfunction

  function automatic bit ramp_due();
    return p_fresh || (int'(p_elapsed) > int'(p_period));
  endfunction

  function automatic void stamp_step();
    p_fresh   = 1'b0;
    p_elapsed = '0;
  endfunction

  function automatic led_out_t led_predict(logic [2:0] op, logic [2:0] eff,
                                           logic [les_pkg::IVL_W-1:0] ivl,
                                           logic [les_pkg::TBL_IDX_W-1:0] idx,
                                           logic [15:0] val);
    led_out_t       r;
    les_pkg::mode_t tgt;
    int             nxt;
    int             len;
    case (op)
      les_pkg::OP_TICK: begin
        if (p_elapsed < les_pkg::TSS_MAX) p_elapsed = p_elapsed + les_pkg::TSS_W'(1);
        case (p_mode)
          les_pkg::MODE_BLINK: begin
            if (p_fresh) begin
              p_pin = 1'b1;
              stamp_step();
            end else if (int'(p_elapsed) > int'(p_phase[p_slot])) begin
              p_pin = !p_pin;
              len = (c_plen == '0) ? 1 : int'(c_plen);
              if (len > les_pkg::TABLE_DEPTH) len = les_pkg::TABLE_DEPTH;
              nxt = int'(p_slot) + 1;
              p_slot = (nxt >= len) ? '0 : les_pkg::TBL_IDX_W'(nxt);
              stamp_step();
            end
          end
          les_pkg::MODE_BREATHE: if (ramp_due()) begin
            stamp_step();
            p_duty = p_falling ? duty_down(p_duty) : duty_up(p_duty);
            if (p_duty == '0 || p_duty >= c_full) p_falling = !p_falling;
          end
          les_pkg::MODE_PULSE: if (ramp_due()) begin
            stamp_step();
            if (p_duty < les_pkg::DUTY_W'(c_step)) begin
              p_duty    = c_full;
              p_elapsed = les_pkg::TSS_GAP;
            end else begin
              p_duty = p_duty - les_pkg::DUTY_W'(c_step);
            end
          end
          les_pkg::MODE_FADE_IN: if (p_duty < c_full && ramp_due()) begin
            stamp_step();
            p_duty = duty_up(p_duty);
            if (p_duty == c_full) to_on();
          end
          les_pkg::MODE_FADE_OUT: if (p_duty != '0 && ramp_due()) begin
            stamp_step();
            p_duty = duty_down(p_duty);
            if (p_duty == '0) to_off();
          end
          default: ;
        endcase
      end
      les_pkg::OP_START: if (eff <= les_pkg::EFF_LAST) begin
        tgt = les_pkg::mode_t'(eff + les_pkg::MODE_BLINK);
        if (p_mode != tgt && p_mode != les_pkg::MODE_OFF) to_off();
        if (tgt == les_pkg::MODE_BLINK) begin
          p_slot  = '0;
          p_fresh = 1'b1;
        end else begin
          p_period = ivl;
          p_duty   = (tgt == les_pkg::MODE_PULSE || tgt == les_pkg::MODE_FADE_OUT) ?
                     c_full : '0;
        end
        p_mode = tgt;
      end
      les_pkg::OP_ON:    to_on();
      les_pkg::OP_OFF:   to_off();
      les_pkg::OP_PAUSE: halt_cyclic();
      les_pkg::OP_RESUME: if (is_cyclic(p_prev)) begin
        if (p_prev == les_pkg::MODE_BREATHE) p_duty = '0;
        else if (p_prev == les_pkg::MODE_PULSE) p_duty = c_full;
        p_mode = p_prev;
        p_prev = les_pkg::MODE_OFF;
      end
      les_pkg::OP_LOAD: p_phase[idx] = val;
      default: ;
    endcase
    r.led   = (p_mode == les_pkg::MODE_ON) || (p_mode == les_pkg::MODE_BLINK && p_pin);
    r.pwm   = p_mode >= les_pkg::MODE_BREATHE && p_mode <= les_pkg::MODE_FADE_OUT;
    r.duty  = r.pwm ? p_duty : '0;
    r.state = p_mode;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_mismatch++;
    if (n_mismatch <= PRINT_CAP)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    led_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_led_q.size() == 0) begin
        report_mismatch("result with no pending transaction", 32'(out_tdata), 32'(0));
      end else begin
        want = pending_led_q.pop_front();
        if (out_tdata[0] !== want.led)
          report_mismatch("led_level", 32'(out_tdata[0]), 32'(want.led));
        if (out_tdata[1] !== want.pwm)
          report_mismatch("pwm_active", 32'(out_tdata[1]), 32'(want.pwm));
        if (out_tdata[les_pkg::DUTY_W+1:2] !== want.duty)
          report_mismatch("pwm_duty", 32'(out_tdata[les_pkg::DUTY_W+1:2]), 32'(want.duty));
        if (out_tdata[les_pkg::DUTY_W+4:les_pkg::DUTY_W+2] !== want.state)
          report_mismatch("effect_state",
                          32'(out_tdata[les_pkg::DUTY_W+4:les_pkg::DUTY_W+2]),
                          32'(want.state));
      end
    end
  end

  // output backpressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] op, logic [2:0] eff, logic [les_pkg::IVL_W-1:0] ivl,
                           logic [les_pkg::TBL_IDX_W-1:0] idx, logic [15:0] val);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, val, idx, ivl, eff};
    do @(posedge clk); while (!in_tready);
    pending_led_q.push_back(led_predict(op, eff, ivl, idx, val));
    items_sent++;
  endtask

  // unused fields carry random bits
  task automatic send_cmd(logic [2:0] op);
    send_item(op, 3'($urandom), les_pkg::IVL_W'($urandom), les_pkg::TBL_IDX_W'($urandom),
              16'($urandom));
  endtask

  task automatic send_start(logic [2:0] eff, logic [les_pkg::IVL_W-1:0] ivl);
    send_item(les_pkg::OP_START, eff, ivl, les_pkg::TBL_IDX_W'($urandom), 16'($urandom));
  endtask

  task automatic send_load(logic [les_pkg::TBL_IDX_W-1:0] idx, logic [15:0] val);
    send_item(les_pkg::OP_LOAD, 3'($urandom), les_pkg::IVL_W'($urandom), idx, val);
  endtask

  task automatic tick_run(int n);
    repeat (n) send_cmd(les_pkg::OP_TICK);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_led_q.size() != 0);
  endtask

  task automatic write_reg(les_pkg::reg_idx_t r, logic [les_pkg::CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      les_pkg::REG_BRIGHT_STEP:    c_step = v[les_pkg::STEP_W-1:0];
      les_pkg::REG_LEVEL_MAX:      c_full = v[les_pkg::DUTY_W-1:0];
      les_pkg::REG_PATTERN_LENGTH: c_plen = v[les_pkg::PLEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] step_v, logic [15:0] full_v, logic [15:0] plen_v);
    wait_idle();
    write_reg(les_pkg::REG_BRIGHT_STEP, step_v);
    write_reg(les_pkg::REG_LEVEL_MAX, full_v);
    write_reg(les_pkg::REG_PATTERN_LENGTH, plen_v);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [les_pkg::IVL_W-1:0] rand_interval();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return les_pkg::IVL_W'($urandom_range(0, 3));
    if (r < 9) return les_pkg::IVL_W'($urandom_range(4, 12));
    return les_pkg::IVL_W'($urandom);
  endfunction

  function automatic logic [15:0] rand_phase_ticks();
    if ($urandom_range(0, 11) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 4));
  endfunction

  task automatic random_phase(int n_items);
    int stop_at;
    int pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) src_idle_en = !src_idle_en;
      if ($urandom_range(0, 9) == 0) sink_idle_en = !sink_idle_en;
      if ($urandom_range(0, 39) == 0) wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_start(3'($urandom_range(0, int'(les_pkg::EFF_LAST))), rand_interval());
        tick_run($urandom_range(1, 24));
      end else if (pick < 62) begin
        tick_run($urandom_range(1, 12));
      end else if (pick < 70) begin
        send_cmd(les_pkg::OP_PAUSE);
        tick_run($urandom_range(0, 4));
        send_cmd(les_pkg::OP_RESUME);
      end else if (pick < 75) begin
        send_cmd(les_pkg::OP_RESUME);
      end else if (pick < 80) begin
        send_cmd(les_pkg::OP_ON);
      end else if (pick < 85) begin
        send_cmd(les_pkg::OP_OFF);
      end else if (pick < 94) begin
        send_load(les_pkg::TBL_IDX_W'($urandom), rand_phase_ticks());
      end else if (pick < 97) begin
        send_cmd(CODE_MAX);
      end else begin
        send_start(3'($urandom_range(int'(les_pkg::EFF_LAST) + 1, int'(CODE_MAX))),
                   rand_interval());
      end
    end
  endtask

  // every blink slot gets a value before any blink can read it
  task automatic table_load_test();
    send_load(3'd0, 16'd0);
    send_load(3'd1, 16'd1);
    for (int i = 2; i < les_pkg::TABLE_DEPTH - 1; i++)
      send_load(les_pkg::TBL_IDX_W'(i), 16'($urandom_range(0, 4)));
    send_load(les_pkg::TBL_IDX_W'(les_pkg::TABLE_DEPTH - 1), 16'hFFFF);
    send_load(les_pkg::TBL_IDX_W'(les_pkg::TABLE_DEPTH - 1), 16'd2);
  endtask

  task automatic command_test();
    send_start(EFF_BLINK, '1);
    tick_run(4);
    send_cmd(les_pkg::OP_PAUSE);
    send_cmd(les_pkg::OP_TICK);
    send_cmd(les_pkg::OP_RESUME);
    send_cmd(les_pkg::OP_TICK);
    send_cmd(les_pkg::OP_ON);
    send_start(EFF_BREATHE, '0);
    tick_run(2);
    send_cmd(les_pkg::OP_PAUSE);
    send_cmd(les_pkg::OP_RESUME);
    send_cmd(les_pkg::OP_OFF);
    send_cmd(les_pkg::OP_RESUME);
    send_start(EFF_PULSE, '1);
    send_cmd(les_pkg::OP_TICK);
    send_start(EFF_FADE_IN, '0);
    send_cmd(les_pkg::OP_TICK);
    send_start(EFF_FADE_OUT, '0);
    send_cmd(les_pkg::OP_TICK);
    send_cmd(CODE_MAX);
    send_start(CODE_MAX, '0);
  endtask

  task automatic config_sweep_test();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    random_phase(40);
    set_config(16'd255, 16'hFFFF, 16'd8);
    random_phase(35);
    set_config(16'd1, 16'd1, 16'd1);
    random_phase(35);
    // zero step, zero full scale, zero pattern length
    set_config(16'd0, 16'd0, 16'd0);
    random_phase(25);
    set_config(16'($urandom_range(1, 40)), 16'($urandom_range(20, 300)), 16'd15);
    random_phase(35);
    set_config(16'($urandom_range(1, 255)), 16'($urandom_range(1, 400)),
               16'($urandom_range(1, les_pkg::TABLE_DEPTH)));
    random_phase(40);
  endtask

  // a wrap to full scale holds off the next step for the pulse gap
  task automatic pulse_gap_test();
    set_config(16'd50, 16'd100, 16'd2);
    send_start(EFF_PULSE, '0);
    tick_run(les_pkg::PULSE_GAP_TICKS + 30);
  endtask

  // closing stretch with no idling on either side
  task automatic back_to_back_test();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_config(16'd3, 16'd20, 16'd4);
    send_start(EFF_BLINK, '0);
    tick_run(12);
    send_start(EFF_BREATHE, 16'd1);
    tick_run(12);
    send_cmd(les_pkg::OP_PAUSE);
    send_cmd(les_pkg::OP_RESUME);
    send_start(EFF_FADE_OUT, '0);
    tick_run(8);
    send_start(EFF_FADE_IN, '0);
    tick_run(8);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    table_load_test();
    command_test();
    config_sweep_test();
    pulse_gap_test();
    back_to_back_test();
    wait_idle();
    repeat (4) @(posedge clk);
    if (n_mismatch == 0 && pending_led_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
